>>> rtl/thb_pkg.sv
package thb_pkg;

  localparam int DEPTH = 256;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int RATIO_W = 5;
  localparam int CFG_DW = 64;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_COMPRESS_RATIO = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COMPRESS_SKIP = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_DIST_SQ = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SAVE_TIME = 2'd3;

  localparam logic ACTION_ADD = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef struct packed {
    logic action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] scalar_value;
    logic scalar_present;
    logic [31:0] time_stamp;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic found;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic out_point_valid;
    logic signed [31:0] out_scalar;
    logic out_scalar_valid;
    logic [31:0] out_time;
    logic out_time_valid;
    logic [8:0] stored_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] scalar;
    logic scalar_ok;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIFF,
    S_SQUARE,
    S_SUM1,
    S_SUM2,
    S_WRITE,
    S_DEC_RD,
    S_DEC_WR,
    S_RESULT,
    S_READ_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic rd_ix;
    logic rd_src;
    logic ld_diff;
    logic ld_sq;
    logic ld_sum1;
    logic ld_sum2;
    logic do_write;
    logic dec_step;
    logic dec_done;
    logic ld_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic gate_needed;
    logic drop;
    logic wrap;
    logic dec_more;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> rtl/thb_if.sv
interface thb_in_if;
  logic valid;
  logic ready;
  thb_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface thb_out_if;
  logic valid;
  logic ready;
  thb_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/thb_ram.sv
module thb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/thb_ctrl.sv
module thb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  thb_pkg::ctrl_status_t status,
  output thb_pkg::ctrl_cmd_t    cmd
);

  thb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= thb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      thb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = thb_pkg::S_CHECK;
        end
      end
      thb_pkg::S_CHECK: begin
        if (status.is_read) begin
          cmd.rd_ix = 1'b1;
          state_next = thb_pkg::S_READ_OUT;
        end else if (status.gate_needed) begin
          state_next = thb_pkg::S_DIFF;
        end else begin
          state_next = thb_pkg::S_WRITE;
        end
      end
      thb_pkg::S_DIFF: begin
        cmd.ld_diff = 1'b1;
        state_next = thb_pkg::S_SQUARE;
      end
      thb_pkg::S_SQUARE: begin
        cmd.ld_sq = 1'b1;
        state_next = thb_pkg::S_SUM1;
      end
      thb_pkg::S_SUM1: begin
        cmd.ld_sum1 = 1'b1;
        state_next = thb_pkg::S_SUM2;
      end
      thb_pkg::S_SUM2: begin
        cmd.ld_sum2 = 1'b1;
        state_next = thb_pkg::S_WRITE;
      end
      thb_pkg::S_WRITE: begin
        cmd.do_write = 1'b1;
        if (!status.drop && status.wrap) begin
          state_next = thb_pkg::S_DEC_RD;
        end else begin
          state_next = thb_pkg::S_RESULT;
        end
      end
      thb_pkg::S_DEC_RD: begin
        if (status.dec_more) begin
          cmd.rd_src = 1'b1;
          state_next = thb_pkg::S_DEC_WR;
        end else begin
          cmd.dec_done = 1'b1;
          state_next = thb_pkg::S_RESULT;
        end
      end
      thb_pkg::S_DEC_WR: begin
        cmd.rd_src = 1'b1;
        cmd.dec_step = 1'b1;
        state_next = thb_pkg::S_DEC_RD;
      end
      thb_pkg::S_RESULT: begin
        if (status.out_free) begin
          cmd.ld_result = 1'b1;
          state_next = thb_pkg::S_IDLE;
        end
      end
      thb_pkg::S_READ_OUT: begin
        cmd.rd_ix = 1'b1;
        if (status.out_free) begin
          cmd.ld_result = 1'b1;
          state_next = thb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = thb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/thb_datapath.sv
module thb_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [thb_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [thb_pkg::CFG_DW-1:0]   cfg_data,
  input  thb_pkg::in_item_t            in_item,
  input  thb_pkg::ctrl_cmd_t           cmd,
  output thb_pkg::ctrl_status_t        status,
  thb_out_if.source                    rsp
);

  logic [thb_pkg::RATIO_W-1:0] compress_ratio;
  logic [thb_pkg::RATIO_W-1:0] compress_skip;
  logic [63:0] min_dist_sq;
  logic save_time;

  thb_pkg::in_item_t item;
  logic [thb_pkg::CW-1:0] write_index;
  logic [thb_pkg::DEPTH-1:0] entry_valid;

  logic [thb_pkg::CW-1:0] dec_src;
  logic [thb_pkg::CW-1:0] dec_dst;

  logic [31:0] mag_x, mag_y, mag_z;
  logic sat_x, sat_y, sat_z;
  logic [63:0] sq_x, sq_y, sq_z;
  logic [63:0] sum1;
  logic drop;

  logic out_valid;
  thb_pkg::out_item_t out_item;

  logic compress_mode;
  logic [thb_pkg::AW-1:0] wi, last, ri, ix;
  logic read_ok;
  logic [thb_pkg::RATIO_W-1:0] ratio, skip;

  logic ram_we;
  logic [thb_pkg::AW-1:0] ram_waddr, ram_raddr;
  thb_pkg::entry_t ram_wdata, ram_rdata, new_entry;

  logic signed [32:0] dx, dy, dz;
  logic [32:0] ax, ay, az;
  logic [64:0] add1, add2;
  logic [63:0] sum2;
  thb_pkg::out_item_t result;

  assign compress_mode = (compress_ratio != '0);
  assign wi = write_index[thb_pkg::AW-1:0];
  assign last = wi - thb_pkg::AW'(1);
  assign ri = item.read_index;
  assign ix = compress_mode ? ri : (wi + ri);
  assign read_ok = compress_mode ? (ri < wi) : 1'b1;
  assign ratio = (compress_ratio < thb_pkg::RATIO_W'(2)) ? thb_pkg::RATIO_W'(2) : compress_ratio;
  assign skip = compress_skip[thb_pkg::RATIO_W-1] ? ratio : compress_skip;

  assign status.is_read = (item.action == thb_pkg::ACTION_READ);
  assign status.gate_needed = (min_dist_sq != '0) && entry_valid[last];
  assign status.drop = drop;
  assign status.wrap = compress_mode && (wi == thb_pkg::AW'(thb_pkg::DEPTH - 1));
  assign status.dec_more = !dec_src[thb_pkg::CW-1];
  assign status.out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      compress_ratio <= '0;
      compress_skip <= '1;
      min_dist_sq <= '0;
      save_time <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        thb_pkg::CFG_COMPRESS_RATIO: compress_ratio <= cfg_data[thb_pkg::RATIO_W-1:0];
        thb_pkg::CFG_COMPRESS_SKIP: compress_skip <= cfg_data[thb_pkg::RATIO_W-1:0];
        thb_pkg::CFG_MIN_DIST_SQ: min_dist_sq <= cfg_data;
        thb_pkg::CFG_SAVE_TIME: save_time <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign new_entry.x = item.point_x;
  assign new_entry.y = item.point_y;
  assign new_entry.z = item.point_z;
  assign new_entry.scalar = item.scalar_value;
  assign new_entry.scalar_ok = item.scalar_present;
  assign new_entry.stamp = item.time_stamp;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = wi;
    ram_wdata = new_entry;
    if (cmd.do_write && !drop) begin
      ram_we = 1'b1;
    end else if (cmd.dec_step) begin
      ram_we = 1'b1;
      ram_waddr = dec_dst[thb_pkg::AW-1:0];
      ram_wdata = ram_rdata;
    end
    if (cmd.rd_src) begin
      ram_raddr = dec_src[thb_pkg::AW-1:0];
    end else if (cmd.rd_ix) begin
      ram_raddr = ix;
    end else begin
      ram_raddr = last;
    end
  end

  thb_ram #(
    .WIDTH ($bits(thb_pkg::entry_t)),
    .DEPTH (thb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    dx = 33'(item.point_x) - 33'($signed(ram_rdata.x));
    dy = 33'(item.point_y) - 33'($signed(ram_rdata.y));
    dz = 33'(item.point_z) - 33'($signed(ram_rdata.z));
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    az = dz[32] ? 33'(-dz) : 33'(dz);
    add1 = {1'b0, sq_x} + {1'b0, sq_y};
    add2 = {1'b0, sum1} + {1'b0, sq_z};
    sum2 = add2[64] ? '1 : add2[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item <= in_item;
    end
    if (cmd.ld_diff) begin
      mag_x <= ax[31:0];
      mag_y <= ay[31:0];
      mag_z <= az[31:0];
      sat_x <= ax[32];
      sat_y <= ay[32];
      sat_z <= az[32];
    end
    if (cmd.ld_sq) begin
      sq_x <= sat_x ? '1 : 64'(mag_x) * 64'(mag_x);
      sq_y <= sat_y ? '1 : 64'(mag_y) * 64'(mag_y);
      sq_z <= sat_z ? '1 : 64'(mag_z) * 64'(mag_z);
    end
    if (cmd.ld_sum1) begin
      sum1 <= add1[64] ? '1 : add1[63:0];
    end
    if (cmd.latch_in) begin
      drop <= 1'b0;
    end else if (cmd.ld_sum2) begin
      drop <= (sum2 < min_dist_sq);
    end
    if (cmd.do_write) begin
      dec_src <= thb_pkg::CW'(skip);
      dec_dst <= '0;
    end else if (cmd.dec_step) begin
      dec_src <= dec_src + thb_pkg::CW'(ratio);
      dec_dst <= dec_dst + thb_pkg::CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      entry_valid <= '0;
    end else begin
      if (cmd.do_write && !drop) begin
        entry_valid[wi] <= 1'b1;
        if (!compress_mode) begin
          write_index <= {1'b0, wi + thb_pkg::AW'(1)};
        end else if (!status.wrap) begin
          write_index <= {1'b0, wi} + thb_pkg::CW'(1);
        end
      end
      if (cmd.dec_step) begin
        entry_valid[dec_dst[thb_pkg::AW-1:0]] <= entry_valid[dec_src[thb_pkg::AW-1:0]];
      end
      if (cmd.dec_done) begin
        write_index <= dec_dst;
      end
    end
  end

  always_comb begin
    result = '0;
    result.stored_count = compress_mode ? write_index : thb_pkg::CW'(thb_pkg::DEPTH);
    if (status.is_read) begin
      result.found = read_ok;
      if (read_ok && entry_valid[ix]) begin
        result.out_x = ram_rdata.x;
        result.out_y = ram_rdata.y;
        result.out_z = ram_rdata.z;
        result.out_point_valid = 1'b1;
        if (ram_rdata.scalar_ok) begin
          result.out_scalar = ram_rdata.scalar;
          result.out_scalar_valid = 1'b1;
        end
        if (save_time) begin
          result.out_time = ram_rdata.stamp;
          result.out_time_valid = 1'b1;
        end
      end
    end else begin
      result.accepted = !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.ld_result) begin
      out_item <= result;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.payload = out_item;

  assert property (@(posedge clk) disable iff (rst)
    cmd.dec_step |-> !dec_src[thb_pkg::CW-1])
    else $error("Decimation copied from beyond the last slot.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.dec_step |-> (dec_dst <= dec_src))
    else $error("Decimation overwrote an entry that was not yet copied.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.ld_result |-> (!out_valid || rsp.ready))
    else $error("A pending result item was overwritten.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.dec_done |=> (write_index <= thb_pkg::CW'(thb_pkg::DEPTH / 2)))
    else $error("Decimation left more than half of the store.");

endmodule

>>> rtl/decimating_trace_history_buffer.sv
// Channel  Role    Payload
// cmd      sink    action, point, scalar, time stamp, read index
// rsp      source  accepted, found, entry fields, stored count
// cfg      write   cfg_we, cfg_index, cfg_data (no read-back)
//
// An item is handled one at a time by a state machine around one store RAM.
// An add passes CHECK, WRITE and RESULT; gating on the last point adds DIFF, SQUARE, SUM1, SUM2.
// A read passes CHECK and READ_OUT, as the RAM read port is registered.
// An add that fills the last slot in compress mode then decimates: DEC_RD and DEC_WR per kept entry.
// Synchronous reset clears the valid bits, write index, config, output valid and state at once.
// A result item waits in the output register; a stalled sink holds the next item.
module decimating_trace_history_buffer (
  input  logic                       clk,
  input  logic                       rst,
  thb_in_if.sink                     cmd,
  thb_out_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [thb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [thb_pkg::CFG_DW-1:0] cfg_data
);

  thb_pkg::ctrl_cmd_t ctrl_cmd;
  thb_pkg::ctrl_status_t ctrl_status;

  thb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .status   (ctrl_status),
    .cmd      (ctrl_cmd)
  );

  thb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (cmd.payload),
    .cmd       (ctrl_cmd),
    .status    (ctrl_status),
    .rsp       (rsp)
  );

endmodule

>>> tb/thb_trace_checker.sv
module thb_trace_checker (
  input  logic                       clk,
  input  logic                       rst,
  thb_in_if                          cmd,
  thb_out_if                         rsp,
  input  logic                       cfg_we,
  input  logic [thb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [thb_pkg::CFG_DW-1:0] cfg_data,
  output int                         fails,
  output int                         pending,
  output int                         points_kept,
  output int                         points_gated,
  output int                         reads_found,
  output int                         decimations
);

  logic [31:0] hist_x [thb_pkg::DEPTH];
  logic [31:0] hist_y [thb_pkg::DEPTH];
  logic [31:0] hist_z [thb_pkg::DEPTH];
  logic [31:0] hist_scalar [thb_pkg::DEPTH];
  logic hist_scalar_ok [thb_pkg::DEPTH];
  logic [31:0] hist_stamp [thb_pkg::DEPTH];
  logic hist_written [thb_pkg::DEPTH];
  logic [8:0] wr_pos;
  logic [4:0] ratio_reg;
  logic signed [4:0] skip_reg;
  logic [63:0] gate_sq_reg;
  logic keep_stamp_reg;
  thb_pkg::out_item_t expected_results [$];

  initial begin
    fails = 0;
    points_kept = 0;
    points_gated = 0;
    reads_found = 0;
    decimations = 0;
  end

  function automatic logic [63:0] diff_square(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0] m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? -d : d;
    if (m[32]) return '1;
    return {32'd0, m[31:0]} * {32'd0, m[31:0]};
  endfunction

  function automatic logic [63:0] add_saturated(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic decimate_history();
    int step;
    int src;
    int dst;
    step = (ratio_reg < 2) ? 2 : ratio_reg;
    src = (skip_reg < 0) ? step : skip_reg;
    dst = 0;
    while (src < thb_pkg::DEPTH) begin
      hist_x[dst] = hist_x[src];
      hist_y[dst] = hist_y[src];
      hist_z[dst] = hist_z[src];
      hist_scalar[dst] = hist_scalar[src];
      hist_scalar_ok[dst] = hist_scalar_ok[src];
      hist_stamp[dst] = hist_stamp[src];
      hist_written[dst] = hist_written[src];
      dst++;
      src += step;
    end
    wr_pos = dst[8:0];
    decimations++;
  endtask

  task automatic predict_history(input thb_pkg::in_item_t it, output thb_pkg::out_item_t r);
    logic [7:0] w;
    logic [7:0] prev;
    logic [7:0] ix;
    logic [63:0] gap_sq;
    logic drop;
    logic ok;
    r = '0;
    w = wr_pos[7:0];
    if (it.action == thb_pkg::ACTION_ADD) begin
      drop = 1'b0;
      prev = w - 8'd1;
      if (gate_sq_reg != 0 && hist_written[prev]) begin
        gap_sq = diff_square(it.point_x, hist_x[prev]);
        gap_sq = add_saturated(gap_sq, diff_square(it.point_y, hist_y[prev]));
        gap_sq = add_saturated(gap_sq, diff_square(it.point_z, hist_z[prev]));
        drop = gap_sq < gate_sq_reg;
      end
      if (drop) begin
        points_gated++;
      end else begin
        hist_x[w] = it.point_x;
        hist_y[w] = it.point_y;
        hist_z[w] = it.point_z;
        hist_scalar[w] = it.scalar_value;
        hist_scalar_ok[w] = it.scalar_present;
        hist_stamp[w] = it.time_stamp;
        hist_written[w] = 1'b1;
        if (ratio_reg != 0 && w == 8'd255) begin
          decimate_history();
        end else begin
          wr_pos = (ratio_reg != 0) ? {1'b0, w} + 9'd1 : {1'b0, w + 8'd1};
        end
        r.accepted = 1'b1;
        points_kept++;
      end
    end else begin
      if (ratio_reg != 0) begin
        ok = it.read_index < w;
        ix = it.read_index;
      end else begin
        ok = 1'b1;
        ix = w + it.read_index;
      end
      if (ok) begin
        r.found = 1'b1;
        reads_found++;
        if (hist_written[ix]) begin
          r.out_x = hist_x[ix];
          r.out_y = hist_y[ix];
          r.out_z = hist_z[ix];
          r.out_point_valid = 1'b1;
          if (hist_scalar_ok[ix]) begin
            r.out_scalar = hist_scalar[ix];
            r.out_scalar_valid = 1'b1;
          end
          if (keep_stamp_reg) begin
            r.out_time = hist_stamp[ix];
            r.out_time_valid = 1'b1;
          end
        end
      end
    end
    r.stored_count = (ratio_reg != 0) ? wr_pos : 9'd256;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (got !== want) begin
      $display("MISMATCH at %0t: %s got %0h expected %0h", $time, field, got, want);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    thb_pkg::out_item_t want;
    thb_pkg::out_item_t got;
    if (rst) begin
      for (int i = 0; i < thb_pkg::DEPTH; i++) hist_written[i] = 1'b0;
      wr_pos = '0;
      ratio_reg = '0;
      skip_reg = -5'sd1;
      gate_sq_reg = '0;
      keep_stamp_reg = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          thb_pkg::CFG_COMPRESS_RATIO: ratio_reg = cfg_data[4:0];
          thb_pkg::CFG_COMPRESS_SKIP: skip_reg = cfg_data[4:0];
          thb_pkg::CFG_MIN_DIST_SQ: gate_sq_reg = cfg_data;
          thb_pkg::CFG_SAVE_TIME: keep_stamp_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        predict_history(cmd.payload, want);
        expected_results = {expected_results, want};
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", 64'd1, 64'd0);
        end else begin
          want = expected_results.pop_front();
          report_mismatch("accepted", got.accepted, want.accepted);
          report_mismatch("found", got.found, want.found);
          report_mismatch("out_x", got.out_x, want.out_x);
          report_mismatch("out_y", got.out_y, want.out_y);
          report_mismatch("out_z", got.out_z, want.out_z);
          report_mismatch("out_point_valid", got.out_point_valid, want.out_point_valid);
          report_mismatch("out_scalar", got.out_scalar, want.out_scalar);
          report_mismatch("out_scalar_valid", got.out_scalar_valid, want.out_scalar_valid);
          report_mismatch("out_time", got.out_time, want.out_time);
          report_mismatch("out_time_valid", got.out_time_valid, want.out_time_valid);
          report_mismatch("stored_count", got.stored_count, want.stored_count);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/decimating_trace_history_buffer_tb.sv
module decimating_trace_history_buffer_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [thb_pkg::CFG_IW-1:0] cfg_index;
  logic [thb_pkg::CFG_DW-1:0] cfg_data;
  int fails;
  int pending;
  int points_kept;
  int points_gated;
  int reads_found;
  int decimations;
  int idle_mode = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  logic [31:0] walk_x = '0;
  logic [31:0] walk_y = '0;
  logic [31:0] walk_z = '0;

  thb_in_if cmd ();
  thb_out_if rsp ();

  decimating_trace_history_buffer DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  thb_trace_checker history_check (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fails(fails),
    .pending(pending),
    .points_kept(points_kept),
    .points_gated(points_gated),
    .reads_found(reads_found),
    .decimations(decimations)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !(idle_mode >= 2 && $urandom_range(99) < (idle_mode == 2 ? 56 : 26));
    end
  end

  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || cfg_we || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("decimating_trace_history_buffer verification failed");
      $finish;
    end
  end

  task automatic send_item(input thb_pkg::in_item_t it);
    while ((idle_mode == 1 || idle_mode == 3) &&
           $urandom_range(99) < (idle_mode == 1 ? 56 : 26)) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.payload <= it;
    do @(posedge clk); while (!cmd.ready);
    items_sent++;
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] ratio, input logic [4:0] skip,
                            input logic [63:0] gate, input logic keep_stamp);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= thb_pkg::CFG_COMPRESS_RATIO;
    cfg_data <= {59'd0, ratio};
    @(posedge clk);
    cfg_index <= thb_pkg::CFG_COMPRESS_SKIP;
    cfg_data <= {59'd0, skip};
    @(posedge clk);
    cfg_index <= thb_pkg::CFG_MIN_DIST_SQ;
    cfg_data <= gate;
    @(posedge clk);
    cfg_index <= thb_pkg::CFG_SAVE_TIME;
    cfg_data <= {63'd0, keep_stamp};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(input logic [31:0] prev);
    int sel;
    int span;
    sel = $urandom_range(99);
    span = ($urandom_range(2) == 0) ? 16 : (($urandom_range(1) == 0) ? 65536 : 1048576);
    if (sel < 60) return prev + $urandom_range(2 * span) - span;
    if (sel < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic thb_pkg::in_item_t random_item(input int read_pct);
    thb_pkg::in_item_t it;
    it.action = ($urandom_range(99) < read_pct) ? thb_pkg::ACTION_READ : thb_pkg::ACTION_ADD;
    it.point_x = pick_coord(walk_x);
    it.point_y = pick_coord(walk_y);
    it.point_z = pick_coord(walk_z);
    it.scalar_value = $urandom;
    it.scalar_present = $urandom_range(3) != 0;
    it.time_stamp = $urandom;
    it.read_index = 8'($urandom_range(255));
    if (it.action == thb_pkg::ACTION_ADD) begin
      walk_x = it.point_x;
      walk_y = it.point_y;
      walk_z = it.point_z;
    end
    return it;
  endfunction

  function automatic thb_pkg::in_item_t read_at(input logic [7:0] idx);
    thb_pkg::in_item_t it;
    it = '0;
    it.action = thb_pkg::ACTION_READ;
    it.read_index = idx;
    return it;
  endfunction

  function automatic thb_pkg::in_item_t add_at(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z, input logic ok,
                                               input logic [31:0] stamp);
    thb_pkg::in_item_t it;
    it = '0;
    it.action = thb_pkg::ACTION_ADD;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.scalar_value = 32'h8000_0001;
    it.scalar_present = ok;
    it.time_stamp = stamp;
    it.read_index = 8'hff;
    walk_x = x;
    walk_y = y;
    walk_z = z;
    return it;
  endfunction

  task automatic run_phase(input int mode, input int count, input logic with_hold);
    idle_mode = mode;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 3) hold_req++;
      if (n == count / 2) drain_results();
      send_item(random_item(25));
    end
    idle_mode = 0;
  endtask

  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.payload = '0;
    rsp.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = thb_pkg::CFG_COMPRESS_RATIO;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A read before any add returns an empty entry.
    set_config(5'd0, 5'h1f, 64'd0, 1'b0);
    send_item(read_at(8'd3));
    for (int n = 0; n < thb_pkg::DEPTH; n++) send_item(random_item(0));

    send_item(read_at(8'd0));
    send_item(read_at(8'd255));
    send_item(add_at(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0, 32'hffff_ffff));
    send_item(add_at(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h0));
    send_item(read_at(8'd255));
    send_item(read_at(8'd254));

    set_config(5'd2, 5'h1f, 64'h0000_0001_0000_0000, 1'b1);
    send_item(read_at(8'd255));
    send_item(read_at(8'd0));
    send_item(add_at(32'h1000, 32'h2000, 32'h3000, 1'b1, 32'h55));
    send_item(add_at(32'h1000, 32'h2000, 32'h3000, 1'b1, 32'h56));
    send_item(add_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h57));
    send_item(add_at(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h58));
    send_item(read_at(8'd0));

    set_config(5'd3, 5'h1f, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_item(add_at(32'h0, 32'h0, 32'h0, 1'b1, 32'h1));
    send_item(add_at(32'h0, 32'h0, 32'h1, 1'b1, 32'h2));
    send_item(add_at(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h3));

    set_config(5'd2, 5'h1f, 64'h0000_0001_0000_0000, 1'b1);
    run_phase(0, 200, 1'b1);
    set_config(5'd16, 5'd15, 64'd0, 1'b1);
    run_phase(1, 180, 1'b0);
    set_config(5'd1, 5'd0, 64'h0000_0100_0000_0000, 1'b0);
    run_phase(2, 180, 1'b1);
    set_config(5'd3, 5'h1f, 64'h0000_0000_0001_0000, 1'b1);
    run_phase(3, 180, 1'b0);
    set_config(5'd7, 5'd5, 64'h0000_0010_0000_0000, 1'b1);
    run_phase(0, 180, 1'b0);
    set_config(5'd0, 5'd15, 64'h0000_0001_0000_0000, 1'b1);
    run_phase(1, 160, 1'b1);
    set_config(5'd2, 5'h10, 64'd0, 1'b0);
    run_phase(3, 200, 1'b0);

    drain_results();
    $display("Sent %0d items: %0d points stored, %0d gated, %0d reads in range.",
             items_sent, points_kept, points_gated, reads_found);
    $display("Store was decimated %0d times across ring and compress settings.",
             decimations);
    if (fails == 0) begin
      $display("decimating_trace_history_buffer verification clean");
    end else begin
      $display("decimating_trace_history_buffer verification failed");
    end
    $finish;
  end

endmodule
